FILE: rtl/core/fdns_pkg.sv
// ----------------------------------------------------------------------------
// fdns_pkg
// Shared types and constants of the directory name scanner.
// ----------------------------------------------------------------------------
package fdns_pkg;

  localparam int unsigned SLOTS     = 13;
  localparam int unsigned SLOT_W    = 4;
  localparam logic [7:0]  CH_SPACE  = 8'h20;
  localparam logic [7:0]  CH_DOT    = 8'h2E;
  localparam logic [7:0]  CH_DEL    = 8'hE5;
  localparam logic [7:0]  CH_END    = 8'h00;
  localparam logic [15:0] UC_NULL   = 16'h0000;
  localparam logic [15:0] UC_PAD    = 16'hFFFF;
  localparam logic [3:0]  ATTR_LFN  = 4'hF;

  // byte offsets of the 13 utf-16 slots inside a long-name entry
  localparam logic [4:0] SLOT_OFFSET [SLOTS] = '{
    5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22,
    5'd24, 5'd28, 5'd30
  };

  typedef enum logic [4:0] {
    OP_RESTART = 5'b00001,
    OP_LFN     = 5'b00010,
    OP_END     = 5'b00100,
    OP_DEL     = 5'b01000,
    OP_LIST    = 5'b10000
  } op_t;

  // one name row: up to 13 characters, each with a keep flag
  typedef struct packed {
    logic [SLOTS-1:0][7:0] chars;
    logic [SLOTS-1:0]      keep;
  } row_t;

  typedef struct packed {
    op_t         op;
    row_t        row;
    logic        is_dir;
    logic [31:0] size;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

endpackage

FILE: rtl/core/fat_directory_name_scanner_unit.sv
// ----------------------------------------------------------------------------
// fat_directory_name_scanner_unit
// Lists names of 32-byte FAT directory entries as packed 8-byte chunks.
// ----------------------------------------------------------------------------
// Each request is one directory entry (or a restart). The front decodes the
// entry in the cycle it is taken and drops it into a two-entry queue; the
// back executes one command at a time. Restart, long-name, deleted and end
// entries are handled in the idle state. A listed entry starts there, walks
// 13 name slots per row, one slot a cycle but holding while a full chunk
// waits on a stalled output, and sends the final chunk from the finish state.
// An 8.3 name is one row; a long name is walked over its stored rows (up to
// 20 with the default MAX_LFN_ENTRIES).
module fat_directory_name_scanner_unit #(
  parameter int MAX_LFN_ENTRIES = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [63:0] in_entry_bytes_0_7,
  input  logic [63:0] in_entry_bytes_8_15,
  input  logic [63:0] in_entry_bytes_16_23,
  input  logic [63:0] in_entry_bytes_24_31,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [63:0] out_name_chars,
  output logic [3:0]  out_char_count,
  output logic        out_is_directory,
  output logic [31:0] out_file_size,
  output logic [15:0] out_file_count,
  output logic        out_last
);
  import fdns_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_full;
  logic q_not_empty;
  logic q_pop;

  assign in_stall = q_full;

  // request decode
  fdns_front u_front (
    .req_type          (in_req_type),
    .entry_bytes_0_7   (in_entry_bytes_0_7),
    .entry_bytes_8_15  (in_entry_bytes_8_15),
    .entry_bytes_16_23 (in_entry_bytes_16_23),
    .entry_bytes_24_31 (in_entry_bytes_24_31),
    .cmd               (front_cmd)
  );

  // command queue
  fdns_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head_cmd)
  );

  // execution
  fdns_back #(
    .MAX_LFN_ENTRIES (MAX_LFN_ENTRIES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_not_empty),
    .q_cmd            (head_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_name_chars   (out_name_chars),
    .out_char_count   (out_char_count),
    .out_is_directory (out_is_directory),
    .out_file_size    (out_file_size),
    .out_file_count   (out_file_count),
    .out_last         (out_last)
  );

endmodule

FILE: rtl/core/fdns_front.sv
// ----------------------------------------------------------------------------
// fdns_front
// Classifies each directory entry and decodes its name slots into a row.
// ----------------------------------------------------------------------------
module fdns_front (
  input  logic                req_type,
  input  logic [63:0]         entry_bytes_0_7,
  input  logic [63:0]         entry_bytes_8_15,
  input  logic [63:0]         entry_bytes_16_23,
  input  logic [63:0]         entry_bytes_24_31,
  output fdns_pkg::cmd_t      cmd
);
  import fdns_pkg::*;

  logic [31:0][7:0] e;
  logic [7:0]       attr;
  row_t             lfn_row;
  row_t             short_row;

  assign e    = {entry_bytes_24_31, entry_bytes_16_23, entry_bytes_8_15, entry_bytes_0_7};
  assign attr = e[11];

  // long-name row: low bytes, each group stops at its first null or pad slot
  always_comb begin
    logic [15:0] uc;
    logic        live;
    lfn_row = '0;
    live    = 1'b1;
    for (int j = 0; j < SLOTS; j++) begin
      if (j == 5 || j == 11) live = 1'b1;
      uc = {e[SLOT_OFFSET[j] + 5'd1], e[SLOT_OFFSET[j]]};
      if (uc == UC_NULL || uc == UC_PAD) live = 1'b0;
      lfn_row.chars[j] = uc[7:0];
      lfn_row.keep[j]  = live;
    end
  end

  // 8.3 row: base up to first space, then dot and extension
  always_comb begin
    logic live;
    short_row = '0;
    live      = 1'b1;
    for (int j = 0; j < 8; j++) begin
      if (e[j] == CH_SPACE) live = 1'b0;
      short_row.chars[j] = e[j];
      short_row.keep[j]  = live;
    end
    live = (e[8] != CH_SPACE);
    short_row.chars[8] = CH_DOT;
    short_row.keep[8]  = live;
    for (int j = 0; j < 3; j++) begin
      if (e[8 + j] == CH_SPACE) live = 1'b0;
      short_row.chars[9 + j] = e[8 + j];
      short_row.keep[9 + j]  = live;
    end
  end

  // classify in priority order
  always_comb begin
    cmd.is_dir = attr[4];
    cmd.size   = entry_bytes_24_31[63:32];
    cmd.row    = short_row;
    priority if (!req_type) begin
      cmd.op = OP_RESTART;
    end else if (attr[3:0] == ATTR_LFN) begin
      cmd.op  = OP_LFN;
      cmd.row = lfn_row;
    end else if (e[0] == CH_END) begin
      cmd.op = OP_END;
    end else if (e[0] == CH_DEL || attr[3]) begin
      cmd.op = OP_DEL;
    end else begin
      cmd.op = OP_LIST;
    end
  end

endmodule

FILE: rtl/core/fdns_queue.sv
// ----------------------------------------------------------------------------
// fdns_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module fdns_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fdns_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output fdns_pkg::cmd_t head
);
  import fdns_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = slot_r[rp_r];

  // pointer and fill update
  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_cmd;
  end

endmodule

FILE: rtl/core/fdns_back.sv
// ----------------------------------------------------------------------------
// fdns_back
// Executes commands: keeps the long-name rows and packs name chunks.
// ----------------------------------------------------------------------------
module fdns_back #(
  parameter int MAX_LFN_ENTRIES = 20
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  fdns_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_result_kind,
  output logic [63:0]    out_name_chars,
  output logic [3:0]     out_char_count,
  output logic           out_is_directory,
  output logic [31:0]    out_file_size,
  output logic [15:0]    out_file_count,
  output logic           out_last
);
  import fdns_pkg::*;

  localparam int CW = $clog2(MAX_LFN_ENTRIES + 1);
  localparam int AW = (MAX_LFN_ENTRIES > 1) ? $clog2(MAX_LFN_ENTRIES) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LFN_ENTRIES);

  row_t               mem [MAX_LFN_ENTRIES];
  row_t               mem_q;
  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      slots_r, slots_nxt;
  logic [15:0]        listed_r, listed_nxt;
  logic               done_r, done_nxt;
  logic [AW-1:0]      ent_r, ent_nxt;
  logic [SLOT_W-1:0]  j_r, j_nxt;
  logic               use_short_r, use_short_nxt;
  row_t               short_r, short_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic               dir_r, dir_nxt;
  logic [31:0]        size_r, size_nxt;

  logic               ov_r, ov_nxt;
  logic               o_kind_r, o_kind_nxt;
  logic [63:0]        o_chars_r, o_chars_nxt;
  logic [3:0]         o_cnt_r, o_cnt_nxt;
  logic               o_dir_r, o_dir_nxt;
  logic [31:0]        o_size_r, o_size_nxt;
  logic [15:0]        o_fc_r, o_fc_nxt;
  logic               o_last_r, o_last_nxt;

  logic               out_free;
  row_t               walk_row;
  logic [7:0]         cur_ch;
  logic               cur_keep;

  assign out_free = !ov_r || !out_stall;
  assign walk_row = use_short_r ? short_r : mem_q;
  assign cur_ch   = walk_row.chars[j_r];
  assign cur_keep = walk_row.keep[j_r];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    slots_nxt     = slots_r;
    listed_nxt    = listed_r;
    done_nxt      = done_r;
    ent_nxt       = ent_r;
    j_nxt         = j_r;
    use_short_nxt = use_short_r;
    short_nxt     = short_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    dir_nxt       = dir_r;
    size_nxt      = size_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = slots_r[AW-1:0];
    rd_en         = 1'b0;
    rd_addr       = AW'(slots_r - CW'(1));
    ov_nxt        = ov_r && out_stall;
    o_kind_nxt    = o_kind_r;
    o_chars_nxt   = o_chars_r;
    o_cnt_nxt     = o_cnt_r;
    o_dir_nxt     = o_dir_r;
    o_size_nxt    = o_size_r;
    o_fc_nxt      = o_fc_r;
    o_last_nxt    = o_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.op == OP_RESTART) begin
            slots_nxt  = '0;
            listed_nxt = '0;
            done_nxt   = 1'b0;
          end else if (!done_r) begin
            unique case (q_cmd.op)
              OP_LFN: begin
                if (slots_r < MAX_CNT) begin
                  wr_en     = 1'b1;
                  slots_nxt = slots_r + CW'(1);
                end
              end
              OP_END: begin
                if (out_free) begin
                  done_nxt    = 1'b1;
                  ov_nxt      = 1'b1;
                  o_kind_nxt  = 1'b1;
                  o_chars_nxt = '0;
                  o_cnt_nxt   = '0;
                  o_dir_nxt   = 1'b0;
                  o_size_nxt  = '0;
                  o_fc_nxt    = listed_r;
                  o_last_nxt  = 1'b1;
                end else begin
                  q_pop = 1'b0;
                end
              end
              OP_DEL: slots_nxt = '0;
              OP_LIST: begin
                dir_nxt   = q_cmd.is_dir;
                size_nxt  = q_cmd.size;
                acc_nxt   = '0;
                cnt_nxt   = '0;
                j_nxt     = '0;
                state_nxt = ST_WALK;
                if (slots_r != '0) begin
                  rd_en         = 1'b1;
                  ent_nxt       = rd_addr;
                  use_short_nxt = 1'b0;
                end else begin
                  ent_nxt       = '0;
                  use_short_nxt = 1'b1;
                  short_nxt     = q_cmd.row;
                end
              end
              default: ;
            endcase
          end
        end
      end

      ST_WALK: begin
        // a full chunk leaves only when another character shows up
        if (!(cur_keep && cnt_r == 4'd8 && !out_free)) begin
          if (cur_keep) begin
            if (cnt_r == 4'd8) begin
              ov_nxt      = 1'b1;
              o_kind_nxt  = 1'b0;
              o_chars_nxt = acc_r;
              o_cnt_nxt   = cnt_r;
              o_dir_nxt   = 1'b0;
              o_size_nxt  = '0;
              o_fc_nxt    = '0;
              o_last_nxt  = 1'b0;
              acc_nxt     = {56'd0, cur_ch};
              cnt_nxt     = 4'd1;
            end else begin
              for (int k = 0; k < 8; k++) begin
                if (cnt_r[2:0] == 3'(k)) acc_nxt[k*8 +: 8] = cur_ch;
              end
              cnt_nxt = cnt_r + 4'd1;
            end
          end
          if (j_r == SLOT_W'(SLOTS - 1)) begin
            j_nxt = '0;
            if (ent_r == '0) begin
              state_nxt = ST_FIN;
            end else begin
              rd_en   = 1'b1;
              rd_addr = ent_r - AW'(1);
              ent_nxt = rd_addr;
            end
          end else begin
            j_nxt = j_r + SLOT_W'(1);
          end
        end
      end

      ST_FIN: begin
        if (out_free) begin
          ov_nxt      = 1'b1;
          o_kind_nxt  = 1'b0;
          o_chars_nxt = acc_r;
          o_cnt_nxt   = cnt_r;
          o_dir_nxt   = dir_r;
          o_size_nxt  = size_r;
          o_fc_nxt    = '0;
          o_last_nxt  = 1'b1;
          slots_nxt   = '0;
          if (listed_r != 16'hFFFF) listed_nxt = listed_r + 16'd1;
          state_nxt   = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      slots_r  <= '0;
      listed_r <= '0;
      done_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      slots_r  <= slots_nxt;
      listed_r <= listed_nxt;
      done_r   <= done_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ent_r       <= ent_nxt;
    j_r         <= j_nxt;
    use_short_r <= use_short_nxt;
    short_r     <= short_nxt;
    acc_r       <= acc_nxt;
    cnt_r       <= cnt_nxt;
    dir_r       <= dir_nxt;
    size_r      <= size_nxt;
    o_kind_r    <= o_kind_nxt;
    o_chars_r   <= o_chars_nxt;
    o_cnt_r     <= o_cnt_nxt;
    o_dir_r     <= o_dir_nxt;
    o_size_r    <= o_size_nxt;
    o_fc_r      <= o_fc_nxt;
    o_last_r    <= o_last_nxt;
  end

  // long-name row memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= q_cmd.row;
    if (rd_en) mem_q <= mem[rd_addr];
  end

  assign out_valid        = ov_r;
  assign out_result_kind  = o_kind_r;
  assign out_name_chars   = o_chars_r;
  assign out_char_count   = o_cnt_r;
  assign out_is_directory = o_dir_r;
  assign out_file_size    = o_size_r;
  assign out_file_count   = o_fc_r;
  assign out_last         = o_last_r;

endmodule
